[hdl/hgtf_pkg.sv]
// ----------------------------------------------------------------------------
// hgtf_pkg
// Types, constants and helper functions of the two-factor Hill rate unit.
// ----------------------------------------------------------------------------
package hgtf_pkg;

  localparam int LOG_STEPS = 16;
  localparam int EXP_STEPS = 16;
  localparam int DIV_STEPS = 30;
  // encode, log, product, magnitude, exp, denominator, divide, select
  localparam int FRAC_LAT  = 1 + LOG_STEPS + 1 + 1 + EXP_STEPS + 1 + DIV_STEPS + 1;
  localparam int BLEND_LAT = 5;
  localparam int TOP_LAT   = FRAC_LAT + BLEND_LAT;

  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [30:0] HALF_Q30 = 31'h2000_0000;

  typedef enum logic [2:0] {
    REG_RATE_UNBOUND      = 3'd0,
    REG_RATE_FIRST_BOUND  = 3'd1,
    REG_RATE_SECOND_BOUND = 3'd2,
    REG_RATE_BOTH_BOUND   = 3'd3,
    REG_HALF_SAT_FIRST    = 3'd4,
    REG_HILL_EXP_FIRST    = 3'd5,
    REG_HALF_SAT_SECOND   = 3'd6,
    REG_HILL_EXP_SECOND   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SPEC_NONE,
    SPEC_HALF,
    SPEC_ZERO,
    SPEC_ONE
  } spec_t;

  typedef struct packed {
    spec_t      spec;
    logic       neg;
    logic       big;
    logic [4:0] sh;
  } exp_side_t;

  // index of the top set bit, 0 for a zero word
  function automatic logic [4:0] lead_one(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bits;
    rem  = v;
    res  = 64'd0;
    bits = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bits) begin
        rem = rem - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  // 2^(2^-(step+1)) in Q2.30, by repeated square roots
  function automatic logic [31:0] exp2_root(input int step);
    logic [63:0] c;
    c = 64'h8000_0000;
    for (int s = 0; s < EXP_STEPS; s++) begin
      if (s <= step) begin
        c = isqrt64(c << 30);
      end
    end
    return c[31:0];
  endfunction

endpackage

[hdl/hgtf_frac.sv]
// ----------------------------------------------------------------------------
// hgtf_frac
// Pipelined bound fraction x^n/(K^n+x^n) in Q.30 via log2, exp2 and divide.
// ----------------------------------------------------------------------------
module hgtf_frac
  import hgtf_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] conc,
  input  logic [31:0] half_sat,
  input  logic [15:0] hill_exp,
  output logic [30:0] frac
);

  // normalise and classify
  logic [31:0] mx_r [LOG_STEPS+1];
  logic [31:0] mk_r [LOG_STEPS+1];
  logic [4:0]  px_r [LOG_STEPS+1];
  logic [4:0]  pk_r [LOG_STEPS+1];
  logic [15:0] fx_r [LOG_STEPS+1];
  logic [15:0] fk_r [LOG_STEPS+1];
  logic [15:0] n_r  [LOG_STEPS+1];
  spec_t       sp_r [LOG_STEPS+1];

  logic [4:0] px_nxt;
  logic [4:0] pk_nxt;
  spec_t      sp_nxt;

  always_comb begin
    px_nxt = lead_one(conc);
    pk_nxt = lead_one(half_sat);
    if (hill_exp == 16'd0) begin
      sp_nxt = SPEC_HALF;
    end else if (conc == 32'd0) begin
      sp_nxt = SPEC_ZERO;
    end else if (half_sat == 32'd0) begin
      sp_nxt = SPEC_ONE;
    end else begin
      sp_nxt = SPEC_NONE;
    end
  end

  always_ff @(posedge clk) begin
    mx_r[0] <= conc << (5'd31 - px_nxt);
    mk_r[0] <= half_sat << (5'd31 - pk_nxt);
    px_r[0] <= px_nxt;
    pk_r[0] <= pk_nxt;
    fx_r[0] <= 16'd0;
    fk_r[0] <= 16'd0;
    n_r[0]  <= hill_exp;
    sp_r[0] <= sp_nxt;
  end

  // log2 fraction, one bit per stage by squaring
  for (genvar j = 1; j <= LOG_STEPS; j++) begin : g_log
    logic [63:0] sqx;
    logic [63:0] sqk;
    assign sqx = mx_r[j-1] * mx_r[j-1];
    assign sqk = mk_r[j-1] * mk_r[j-1];
    always_ff @(posedge clk) begin
      mx_r[j] <= sqx[63] ? sqx[63:32] : sqx[62:31];
      mk_r[j] <= sqk[63] ? sqk[63:32] : sqk[62:31];
      fx_r[j] <= {fx_r[j-1][14:0], sqx[63]};
      fk_r[j] <= {fk_r[j-1][14:0], sqk[63]};
      px_r[j] <= px_r[j-1];
      pk_r[j] <= pk_r[j-1];
      n_r[j]  <= n_r[j-1];
      sp_r[j] <= sp_r[j-1];
    end
  end

  // scaled log difference
  logic signed [20:0] lx;
  logic signed [20:0] lk;
  logic signed [21:0] ldiff;
  logic signed [37:0] d_nxt;
  logic signed [37:0] d_r;
  spec_t              spd_r;

  assign lx    = {px_r[LOG_STEPS] ^ 5'b10000, fx_r[LOG_STEPS]};
  assign lk    = {pk_r[LOG_STEPS] ^ 5'b10000, fk_r[LOG_STEPS]};
  assign ldiff = 22'(lk) - 22'(lx);
  assign d_nxt = ldiff * $signed({1'b0, n_r[LOG_STEPS]});

  always_ff @(posedge clk) begin
    d_r   <= d_nxt;
    spd_r <= sp_r[LOG_STEPS];
  end

  // magnitude split into integer shift and fraction
  logic [37:0] dabs;
  logic [24:0] mag;
  logic [30:0] pw_r [EXP_STEPS+1];
  logic [15:0] r_r  [EXP_STEPS+1];
  exp_side_t   es_r [EXP_STEPS+1];

  assign dabs = d_r[37] ? 38'(-d_r) : 38'(d_r);
  assign mag  = dabs[36:12];

  always_ff @(posedge clk) begin
    pw_r[0]      <= ONE_Q30;
    r_r[0]       <= mag[15:0];
    es_r[0].spec <= spd_r;
    es_r[0].neg  <= d_r[37];
    es_r[0].big  <= (mag[24:16] >= 9'd31);
    es_r[0].sh   <= mag[20:16];
  end

  // exp2 of the fraction, one bit per stage
  for (genvar j = 1; j <= EXP_STEPS; j++) begin : g_exp
    localparam logic [31:0] ROOT = exp2_root(j - 1);
    logic [62:0] prod;
    assign prod = pw_r[j-1] * ROOT;
    always_ff @(posedge clk) begin
      pw_r[j] <= r_r[j-1][EXP_STEPS-j] ? prod[60:30] : pw_r[j-1];
      r_r[j]  <= r_r[j-1];
      es_r[j] <= es_r[j-1];
    end
  end

  // denominator 1 + 2^|d|, then restoring divide into 2^60
  logic [61:0] den_r [DIV_STEPS+1];
  logic [61:0] rem_r [DIV_STEPS+1];
  logic [29:0] q_r   [DIV_STEPS+1];
  exp_side_t   ds_r  [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    den_r[0] <= 62'(ONE_Q30) + ({31'd0, pw_r[EXP_STEPS]} << es_r[EXP_STEPS].sh);
    rem_r[0] <= 62'(ONE_Q30);
    q_r[0]   <= 30'd0;
    ds_r[0]  <= es_r[EXP_STEPS];
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [62:0] rs;
    logic        ge;
    assign rs = {rem_r[j-1], 1'b0};
    assign ge = (rs >= {1'b0, den_r[j-1]});
    always_ff @(posedge clk) begin
      rem_r[j] <= ge ? 62'(rs - {1'b0, den_r[j-1]}) : rs[61:0];
      q_r[j]   <= {q_r[j-1][28:0], ge};
      den_r[j] <= den_r[j-1];
      ds_r[j]  <= ds_r[j-1];
    end
  end

  // final selection
  logic [30:0] g;
  logic [30:0] f_nxt;
  logic [30:0] f_r;

  assign g = ds_r[DIV_STEPS].big ? 31'd0 : {1'b0, q_r[DIV_STEPS]};

  always_comb begin
    case (ds_r[DIV_STEPS].spec)
      SPEC_HALF: f_nxt = HALF_Q30;
      SPEC_ZERO: f_nxt = 31'd0;
      SPEC_ONE:  f_nxt = ONE_Q30;
      default:   f_nxt = ds_r[DIV_STEPS].neg ? 31'(ONE_Q30 - g) : g;
    endcase
  end

  always_ff @(posedge clk) begin
    f_r <= f_nxt;
  end

  assign frac = f_r;

endmodule

[hdl/hill_general_two_factor.sv]
// throughput: one item per cycle, busy is never raised
// the divide stages of the fraction units set the depth (one quotient bit each)
// reset: synchronous, clears the valid line and loads register defaults
// the receiver cannot stall, each result is shown for one cycle
// ----------------------------------------------------------------------------
// hill_general_two_factor
// Two-factor Hill rate per cell, added to the running derivative with clipping.
// ----------------------------------------------------------------------------
module hill_general_two_factor
  import hgtf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_conc_first,
  input  logic [31:0] in_conc_second,
  input  logic [31:0] in_deriv_in,
  output logic        out_valid,
  output logic [31:0] out_deriv_out,
  output logic        out_saturated,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic signed [31:0] rate_unbound_r;
  logic signed [31:0] rate_first_bound_r;
  logic signed [31:0] rate_second_bound_r;
  logic signed [31:0] rate_both_bound_r;
  logic [31:0]        half_sat_first_r;
  logic [15:0]        hill_exp_first_r;
  logic [31:0]        half_sat_second_r;
  logic [15:0]        hill_exp_second_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_unbound_r      <= 32'sd0;
      rate_first_bound_r  <= 32'sd0;
      rate_second_bound_r <= 32'sd0;
      rate_both_bound_r   <= 32'sd0;
      half_sat_first_r    <= 32'h0001_0000;
      hill_exp_first_r    <= 16'h1000;
      half_sat_second_r   <= 32'h0001_0000;
      hill_exp_second_r   <= 16'h1000;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_RATE_UNBOUND:      rate_unbound_r      <= cfg_data;
        REG_RATE_FIRST_BOUND:  rate_first_bound_r  <= cfg_data;
        REG_RATE_SECOND_BOUND: rate_second_bound_r <= cfg_data;
        REG_RATE_BOTH_BOUND:   rate_both_bound_r   <= cfg_data;
        REG_HALF_SAT_FIRST:    half_sat_first_r    <= cfg_data;
        REG_HILL_EXP_FIRST:    hill_exp_first_r    <= cfg_data[15:0];
        REG_HALF_SAT_SECOND:   half_sat_second_r   <= cfg_data;
        REG_HILL_EXP_SECOND:   hill_exp_second_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // valid and derivative delay lines
  logic               vld_r [TOP_LAT];
  logic signed [31:0] dly_r [TOP_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOP_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= accept;
      for (int i = 1; i < TOP_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dly_r[0] <= in_deriv_in;
    for (int i = 1; i < TOP_LAT - 1; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  logic [30:0] a1;
  logic [30:0] a2;

  hgtf_frac u_frac_first (
    .clk      (clk),
    .conc     (in_conc_first),
    .half_sat (half_sat_first_r),
    .hill_exp (hill_exp_first_r),
    .frac     (a1)
  );

  hgtf_frac u_frac_second (
    .clk      (clk),
    .conc     (in_conc_second),
    .half_sat (half_sat_second_r),
    .hill_exp (hill_exp_second_r),
    .frac     (a2)
  );

  // blend over the second factor
  logic [30:0]        b2;
  logic signed [63:0] p00_r;
  logic signed [63:0] p01_r;
  logic signed [63:0] p10_r;
  logic signed [63:0] p11_r;
  logic [30:0]        a1_b1_r;
  logic [30:0]        a1_b2_r;

  assign b2 = 31'(ONE_Q30 - a2);

  always_ff @(posedge clk) begin
    p00_r   <= rate_unbound_r      * $signed({1'b0, b2});
    p01_r   <= rate_second_bound_r * $signed({1'b0, a2});
    p10_r   <= rate_first_bound_r  * $signed({1'b0, b2});
    p11_r   <= rate_both_bound_r   * $signed({1'b0, a2});
    a1_b1_r <= a1;
  end

  logic signed [64:0] s0;
  logic signed [64:0] s1;
  logic signed [32:0] t0_r;
  logic signed [32:0] t1_r;

  assign s0 = p00_r + p01_r + 65'sd536870912;
  assign s1 = p10_r + p11_r + 65'sd536870912;

  always_ff @(posedge clk) begin
    t0_r    <= s0[62:30];
    t1_r    <= s1[62:30];
    a1_b2_r <= a1_b1_r;
  end

  // blend over the first factor
  logic [30:0]        b1;
  logic signed [64:0] q0_r;
  logic signed [64:0] q1_r;

  assign b1 = 31'(ONE_Q30 - a1_b2_r);

  always_ff @(posedge clk) begin
    q0_r <= t0_r * $signed({1'b0, b1});
    q1_r <= t1_r * $signed({1'b0, a1_b2_r});
  end

  logic signed [65:0] sr;
  logic signed [32:0] rate_r;

  assign sr = q0_r + q1_r + 66'sd536870912;

  always_ff @(posedge clk) begin
    rate_r <= sr[62:30];
  end

  // add and clip
  logic signed [33:0] sum;
  logic [31:0]        dout_nxt;
  logic               sat_nxt;
  logic [31:0]        dout_r;
  logic               sat_r;

  assign sum = 34'(dly_r[TOP_LAT-2]) + 34'(rate_r);

  always_comb begin
    if (sum > 34'sd2147483647) begin
      dout_nxt = 32'h7FFF_FFFF;
      sat_nxt  = 1'b1;
    end else if (sum < -34'sd2147483648) begin
      dout_nxt = 32'h8000_0000;
      sat_nxt  = 1'b1;
    end else begin
      dout_nxt = sum[31:0];
      sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    dout_r <= dout_nxt;
    sat_r  <= sat_nxt;
  end

  assign out_valid     = vld_r[TOP_LAT-1];
  assign out_deriv_out = dout_r;
  assign out_saturated = sat_r;

  a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_deriv_out == 32'h7FFF_FFFF || out_deriv_out == 32'h8000_0000))
    else $error("clipped item not at a range limit");

  a_frac_first: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[FRAC_LAT-1] |-> (a1 <= ONE_Q30))
    else $error("first fraction above one");

  a_frac_second: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[FRAC_LAT-1] |-> (a2 <= ONE_Q30))
    else $error("second fraction above one");

endmodule
